// ===== design/cpgl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package cpgl_pkg;

  // item kinds
  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  localparam int CountW = 5;
  localparam int CodeW  = 16;
  localparam int SlotW  = 4;

  typedef struct packed {
    logic             kind;
    logic [SlotW-1:0] entry_slot;
    logic [CodeW-1:0] first_code;
    logic [CodeW-1:0] end_code;
    logic [CodeW-1:0] code_point;
  } in_item_t;

  typedef struct packed {
    logic             found;
    logic [CodeW-1:0] glyph_index;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic start;  // latch lookup, point at slot 0
    logic wr;     // store a range entry
    logic step;   // move to next slot, accumulate offset
    logic ld;     // load output register
    logic hit;    // loaded value is a hit
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic lt_first;  // code point below current range begin
    logic lt_end;    // code point below current range end
    logic last;      // current slot is the last one searched
    logic empty;     // nothing to search
  } sts_t;

endpackage

`default_nettype wire

// ===== design/cpgl_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cpgl_ctrl
  import cpgl_pkg::*;
(
  input  wire  clk,
  input  wire  rst,
  input  wire  in_valid,
  output logic in_ready,
  input  wire  in_kind,
  output logic out_valid,
  input  wire  out_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIN
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_valid_next;
  logic   in_acc;
  logic   out_free;

  assign in_ready = (state == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // command decode and next state
  always_comb begin
    cmd            = '0;
    state_next     = state;
    out_valid_next = out_valid && !out_ready;
    unique case (state)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_kind == KIND_WRITE) begin
            cmd.wr     = 1'b1;
            state_next = ST_FIN;
          end else begin
            cmd.start  = 1'b1;
            state_next = sts.empty ? ST_FIN : ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (sts.lt_first || sts.lt_end || sts.last) begin
          // transaction ends here, wait for room in the output register
          if (out_free) begin
            cmd.ld         = 1'b1;
            cmd.hit        = !sts.lt_first && sts.lt_end;
            out_valid_next = 1'b1;
            state_next     = ST_IDLE;
          end
        end else begin
          cmd.step = 1'b1;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          cmd.ld         = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

`default_nettype wire

// ===== design/cpgl_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cpgl_dp
  import cpgl_pkg::*;
#(
  parameter int MAX_RANGES = 16
) (
  input  wire               clk,
  input  wire               rst,
  input  wire               cfg_we,
  input  wire  [CountW-1:0] cfg_wdata,
  input  in_item_t          in_item,
  input  cmd_t              cmd,
  output sts_t              sts,
  output out_item_t         out_item
);

  localparam int AW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
  localparam int SW = (AW > SlotW) ? AW : SlotW;
  localparam int IW = (AW > CountW) ? AW : CountW;

  logic [CodeW-1:0]  first_mem [MAX_RANGES];
  logic [CodeW-1:0]  end_mem   [MAX_RANGES];
  logic [CodeW-1:0]  rd_first;
  logic [CodeW-1:0]  rd_end;

  logic [CountW-1:0] range_count;
  logic [CountW-1:0] limit;
  logic [CountW-1:0] idx;
  logic [CountW-1:0] idx_next;
  logic [CodeW-1:0]  cp;
  logic [CodeW-1:0]  offset;

  logic [SW-1:0]     slot_ext;
  logic [AW-1:0]     wr_addr;
  logic [IW-1:0]     idx_ext;
  logic [AW-1:0]     rd_addr;
  logic              slot_ok;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      range_count <= '0;
    end else if (cfg_we) begin
      range_count <= cfg_wdata;
    end
  end

  // counts above the table depth search the whole table
  assign limit = (int'(range_count) > MAX_RANGES) ? CountW'(MAX_RANGES) : range_count;

  // scan index; the read address follows the next value so data lines up
  always_comb begin
    idx_next = idx;
    if (cmd.start) begin
      idx_next = '0;
    end else if (cmd.step) begin
      idx_next = idx + CountW'(1);
    end
  end

  assign slot_ext = SW'(in_item.entry_slot);
  assign wr_addr  = slot_ext[AW-1:0];
  assign slot_ok  = int'(in_item.entry_slot) < MAX_RANGES;
  assign idx_ext  = IW'(idx_next);
  assign rd_addr  = idx_ext[AW-1:0];

  // range table, one write port and one registered read port
  always_ff @(posedge clk) begin
    if (cmd.wr && slot_ok) begin
      first_mem[wr_addr] <= in_item.first_code;
      end_mem[wr_addr]   <= in_item.end_code;
    end
    rd_first <= first_mem[rd_addr];
    rd_end   <= end_mem[rd_addr];
  end

  // lookup state: code point, slot index, running glyph offset
  always_ff @(posedge clk) begin
    idx <= idx_next;
    if (cmd.start) begin
      cp     <= in_item.code_point;
      offset <= '0;
    end else if (cmd.step) begin
      offset <= offset + (rd_end - rd_first);
    end
  end

  // status for the controller
  assign sts.lt_first = cp < rd_first;
  assign sts.lt_end   = cp < rd_end;
  assign sts.last     = ({1'b0, idx} + (CountW + 1)'(1)) >= {1'b0, limit};
  assign sts.empty    = (limit == '0);

  // output register
  always_ff @(posedge clk) begin
    if (cmd.ld) begin
      out_item.found       <= cmd.hit;
      out_item.glyph_index <= cmd.hit ? (offset + (cp - rd_first)) : '0;
    end
  end

endmodule

`default_nettype wire

// ===== design/code_point_range_glyph_lookup.sv =====
// channel   signals                      handshake    payload
// in        in_valid/in_ready/in_item    valid-ready  kind, slot, first, end, code point
// out       out_valid/out_ready/out_item valid-ready  found, glyph_index
// cfg       cfg_we/cfg_wdata             write only   range_count
//
// a write transaction stores its entry on accept, then loads its result from ST_FIN
// a lookup visits at most min(range_count, MAX_RANGES) ranges and goes straight to ST_FIN
// when nothing is searched; the scan walks one range per cycle through the read port
// the output register frees the input side once a result is loaded
// a stalled output holds the finished result and the scan pauses on its last range
// reset clears the controller, output valid and range_count; the table is not cleared
`timescale 1ns / 1ps
`default_nettype none

module code_point_range_glyph_lookup
  import cpgl_pkg::*;
#(
  parameter int MAX_RANGES = 16
) (
  input  wire               clk,
  input  wire               rst,
  input  wire               in_valid,
  output logic              in_ready,
  input  in_item_t          in_item,
  output logic              out_valid,
  input  wire               out_ready,
  output out_item_t         out_item,
  input  wire               cfg_we,
  input  wire  [CountW-1:0] cfg_wdata
);

  cmd_t cmd;
  sts_t sts;

  // sequencer
  cpgl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_kind   (in_item.kind),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // table, scan arithmetic and output register
  cpgl_dp #(
    .MAX_RANGES (MAX_RANGES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_item   (in_item),
    .cmd       (cmd),
    .sts       (sts),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

// ===== design/cpgl_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cpgl_checker
  import cpgl_pkg::*;
(
  input wire       clk,
  input wire       rst,
  input wire       in_valid,
  input wire       in_ready,
  input in_item_t  in_item,
  input wire       out_valid,
  input wire       out_ready,
  input out_item_t out_item
);

  // a held result does not change
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  // a miss always reports index zero
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_item.found |-> out_item.glyph_index == '0)
    else $error("miss with nonzero glyph index");

  // one transaction at a time: busy right after an accept
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted a second transaction while busy");

  // no result straight out of reset
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind code_point_range_glyph_lookup cpgl_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);

`default_nettype wire
